FILE: hw/rtl/sampled_latency_histogram_macros.svh
// ----------------------------------------------------------------------------
// Sampled latency histogram: assertion macros
// Concurrent checks on clk, off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SAMPLED_LATENCY_HISTOGRAM_MACROS_SVH
`define SAMPLED_LATENCY_HISTOGRAM_MACROS_SVH

`ifndef ASSERT_OFF
`define SLH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SLH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SLH_ASSERT(lbl, prop, msg)
`define SLH_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/slh_pkg.sv
// ----------------------------------------------------------------------------
// slh_pkg
// Sizes, codes and address helper for the sampled latency histogram.
// ----------------------------------------------------------------------------
package slh_pkg;

	localparam int RINGS      = 16;
	localparam int BINS       = 64;
	localparam int ACT_W      = 2;
	localparam int RING_W     = 4;
	localparam int BIN_W      = 6;
	localparam int TIME_W     = 64;
	localparam int CPN_W      = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int RING_AW    = (RINGS > 1) ? $clog2(RINGS) : 1;
	localparam int HIST_DEPTH = RINGS * BINS;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int SLOT_W     = $clog2(BINS);
	localparam int LIM_W      = SLOT_W + CPN_W;
	localparam int CNT_W      = (SLOT_W > 1) ? $clog2(SLOT_W) : 1;

	localparam logic [ACT_W-1:0] ACT_STAMP   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_MEASURE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CPN      = 1'b1;

	function automatic logic [HIST_AW-1:0] hist_addr(input logic [RING_W-1:0] r,
		input logic [SLOT_W-1:0] s);
		hist_addr = HIST_AW'(r) * HIST_AW'(BINS) + HIST_AW'(s);
	endfunction

endpackage

FILE: hw/rtl/sampled_latency_histogram.sv
// ----------------------------------------------------------------------------
// sampled_latency_histogram
// Per-ring enqueue sampling and dequeue latency histogram with bin read-out.
// ----------------------------------------------------------------------------
// channel | signals                                            | dir
// item    | item_valid item_stall action ring now packet_stamp bin | in
// result  | result_valid result_stall stamp_set stamp_value bin_hit counted bin_count | out
// cfg     | cfg_we cfg_index cfg_data                           | in
//
// One item at a time through a sequencer around two memories.
// Per item: stamp runs ST_ST1, ST_ST2, ST_ST3; read runs ST_RDB; measure runs ST_M1, ST_M2,
// then ST_DIV (6-step shift-subtract divide) when the latency is below the last bin, then ST_MRD, ST_MWR.
// Bad ring, action 3 or a zero packet stamp go straight to ST_OUT, where every item ends.
// After reset a clearing pass over all 1024 histogram entries zeroes both memories; no item is taken.
// A stalled result holds in the output register; the next item is still taken.
`include "sampled_latency_histogram_macros.svh"

module sampled_latency_histogram
	import slh_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [TIME_W-1:0]     cfg_data,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [ACT_W-1:0]      action,
	input  logic [RING_W-1:0]     ring,
	input  logic [TIME_W-1:0]     now,
	input  logic [TIME_W-1:0]     packet_stamp,
	input  logic [BIN_W-1:0]      bin,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic                  stamp_set,
	output logic [TIME_W-1:0]     stamp_value,
	output logic [BIN_W-1:0]      bin_hit,
	output logic                  counted,
	output logic [TIME_W-1:0]     bin_count
);

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_ST1  = 4'd2;
	localparam logic [3:0] ST_ST2  = 4'd3;
	localparam logic [3:0] ST_ST3  = 4'd4;
	localparam logic [3:0] ST_M1   = 4'd5;
	localparam logic [3:0] ST_M2   = 4'd6;
	localparam logic [3:0] ST_DIV  = 4'd7;
	localparam logic [3:0] ST_MRD  = 4'd8;
	localparam logic [3:0] ST_MWR  = 4'd9;
	localparam logic [3:0] ST_RDB  = 4'd10;
	localparam logic [3:0] ST_OUT  = 4'd11;

	logic [3:0]             state_q;
	logic [HIST_AW-1:0]     clr_cnt_q;
	logic [TIME_W-1:0]      interval_q;
	logic [CPN_W-1:0]       cpn_q;

	logic [ACT_W-1:0]       act_q;
	logic [RING_W-1:0]      ring_q;
	logic [TIME_W-1:0]      now_q;
	logic [TIME_W-1:0]      pstamp_q;
	logic [BIN_W-1:0]       bin_q;
	logic [TIME_W-1:0]      delta_q;
	logic [TIME_W-1:0]      acc_q;
	logic [TIME_W-1:0]      diff_q;
	logic [CPN_W-1:0]       div_q;
	logic [LIM_W-1:0]       rem_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [CNT_W-1:0]       cnt_q;

	logic                   res_set_q;
	logic [TIME_W-1:0]      res_value_q;
	logic [BIN_W-1:0]       res_hit_q;
	logic                   res_counted_q;
	logic [TIME_W-1:0]      res_count_q;

	logic                   result_valid_q;
	logic                   stamp_set_q;
	logic [TIME_W-1:0]      stamp_value_q;
	logic [BIN_W-1:0]       bin_hit_q;
	logic                   counted_q;
	logic [TIME_W-1:0]      bin_count_q;

	logic [2*TIME_W-1:0]    ring_mem [RINGS];
	logic [2*TIME_W-1:0]    ring_rdata_q;
	logic [RING_AW-1:0]     ring_raddr;
	logic [RING_AW-1:0]     ring_waddr;
	logic [2*TIME_W-1:0]    ring_wdata;
	logic                   ring_we;

	logic [TIME_W-1:0]      hist_mem [HIST_DEPTH];
	logic [TIME_W-1:0]      hist_rdata_q;
	logic [HIST_AW-1:0]     hist_raddr;
	logic [HIST_AW-1:0]     hist_waddr;
	logic [TIME_W-1:0]      hist_wdata;
	logic                   hist_we;

	logic                   item_acc;
	logic                   ring_ok;
	logic                   bin_ok_q;
	logic                   out_load;
	logic                   stamp_hit;
	logic [LIM_W-1:0]       lim;
	logic                   sat;
	logic [LIM_W:0]         trial;

	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign ring_ok    = {1'b0, ring} < (RING_W+1)'(RINGS);
	assign out_load   = (state_q == ST_OUT) && (!result_valid_q || !result_stall);
	assign stamp_hit  = acc_q >= interval_q;
	assign lim        = LIM_W'(BINS - 1) * LIM_W'(div_q);
	assign sat        = (diff_q[TIME_W-1:LIM_W] != '0) || (diff_q[LIM_W-1:0] >= lim);
	assign trial      = {1'b0, rem_q} - ((LIM_W+1)'(div_q) << cnt_q);

	// memory addressing
	always_comb begin
		ring_raddr = (state_q == ST_IDLE) ? RING_AW'(ring) : RING_AW'(ring_q);
		if (state_q == ST_IDLE) begin
			hist_raddr = hist_addr(ring, SLOT_W'(bin));
		end else if (act_q == ACT_MEASURE) begin
			hist_raddr = hist_addr(ring_q, slot_q);
		end else begin
			hist_raddr = hist_addr(ring_q, SLOT_W'(bin_q));
		end
		ring_we    = 1'b0;
		ring_waddr = RING_AW'(ring_q);
		ring_wdata = {(stamp_hit ? {TIME_W{1'b0}} : acc_q), now_q};
		hist_we    = 1'b0;
		hist_waddr = hist_raddr;
		hist_wdata = hist_rdata_q + TIME_W'(1);
		case (state_q)
			ST_CLR: begin
				ring_we    = {1'b0, clr_cnt_q} < (HIST_AW+1)'(RINGS);
				ring_waddr = RING_AW'(clr_cnt_q);
				ring_wdata = '0;
				hist_we    = 1'b1;
				hist_waddr = clr_cnt_q;
				hist_wdata = '0;
			end
			ST_ST3: ring_we = 1'b1;
			ST_MWR: hist_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_waddr] <= ring_wdata;
		end
		ring_rdata_q <= ring_mem[ring_raddr];
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		hist_rdata_q <= hist_mem[hist_raddr];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLR;
			clr_cnt_q      <= '0;
			interval_q     <= '0;
			cpn_q          <= CPN_W'(1);
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_INTERVAL: interval_q <= cfg_data;
					CFG_CPN:      cpn_q      <= cfg_data[CPN_W-1:0];
					default: ;
				endcase
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + HIST_AW'(1);
					if (clr_cnt_q == HIST_AW'(HIST_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_acc) begin
						if (!ring_ok) begin
							state_q <= ST_OUT;
						end else begin
							case (action)
								ACT_STAMP:   state_q <= ST_ST1;
								ACT_MEASURE: state_q <= (packet_stamp == '0) ? ST_OUT : ST_M1;
								ACT_READ:    state_q <= ST_RDB;
								default:     state_q <= ST_OUT;
							endcase
						end
					end
				end
				ST_ST1: state_q <= ST_ST2;
				ST_ST2: state_q <= ST_ST3;
				ST_ST3: state_q <= ST_OUT;
				ST_M1:  state_q <= ST_M2;
				ST_M2:  state_q <= sat ? ST_MRD : ST_DIV;
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_MRD;
					end
				end
				ST_MRD: state_q <= ST_MWR;
				ST_MWR: state_q <= ST_OUT;
				ST_RDB: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				act_q         <= action;
				ring_q        <= ring;
				now_q         <= now;
				pstamp_q      <= packet_stamp;
				bin_q         <= bin;
				bin_ok_q      <= {1'b0, bin} < (BIN_W+1)'(BINS);
				res_set_q     <= 1'b0;
				res_value_q   <= '0;
				res_hit_q     <= '0;
				res_counted_q <= 1'b0;
				res_count_q   <= '0;
			end
			ST_ST1: begin
				delta_q <= now_q - ring_rdata_q[TIME_W-1:0];
				acc_q   <= ring_rdata_q[2*TIME_W-1:TIME_W];
			end
			ST_ST2: acc_q <= acc_q + delta_q;
			ST_ST3: begin
				res_set_q   <= stamp_hit;
				res_value_q <= stamp_hit ? now_q : '0;
			end
			ST_M1: begin
				diff_q <= now_q - pstamp_q;
				div_q  <= (cpn_q == '0) ? CPN_W'(1) : cpn_q;
			end
			ST_M2: begin
				rem_q  <= diff_q[LIM_W-1:0];
				cnt_q  <= CNT_W'(SLOT_W - 1);
				slot_q <= sat ? SLOT_W'(BINS - 1) : '0;
			end
			ST_DIV: begin
				if (!trial[LIM_W]) begin
					rem_q         <= trial[LIM_W-1:0];
					slot_q[cnt_q] <= 1'b1;
				end
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_MWR: begin
				res_hit_q     <= BIN_W'(slot_q);
				res_counted_q <= 1'b1;
			end
			ST_RDB: res_count_q <= bin_ok_q ? hist_rdata_q : '0;
			default: ;
		endcase
		if (out_load) begin
			stamp_set_q   <= res_set_q;
			stamp_value_q <= res_value_q;
			bin_hit_q     <= res_hit_q;
			counted_q     <= res_counted_q;
			bin_count_q   <= res_count_q;
		end
	end

	assign result_valid = result_valid_q;
	assign stamp_set    = stamp_set_q;
	assign stamp_value  = stamp_value_q;
	assign bin_hit      = bin_hit_q;
	assign counted      = counted_q;
	assign bin_count    = bin_count_q;

	`SLH_ASSERT_IMP(a_rose_from_out, $rose(result_valid_q), $past(state_q) == ST_OUT, "stray beat")
	`SLH_ASSERT_IMP(a_no_result_in_clear, state_q == ST_CLR, !result_valid_q, "beat in clear")
	`SLH_ASSERT(a_one_kind, !(result_valid_q && stamp_set_q && counted_q), "stamp and count")
	`SLH_ASSERT_IMP(a_div_rem, state_q == ST_DIV,
		{1'b0, rem_q} < ((LIM_W+1)'(div_q) << (cnt_q + 1)), "remainder range")

endmodule

FILE: tb/sv/sampled_latency_histogram_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sampled_latency_histogram_test
// Self-checking bench for the per-ring latency histogram. A scoreboard object
// tracks the sampling accumulators, the last stamp times and every bin count,
// predicts one result beat per accepted item and checks the result beats in
// order. A directed run covers the field extremes, timer wrap, unstamped
// packets and the unused action code. Randomised phases follow under several
// register settings, with idle gaps on both channels and one long
// result hold-off.
// ----------------------------------------------------------------------------
module sampled_latency_histogram_test
	import slh_pkg::*;
;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic              stamp_set;
		logic [TIME_W-1:0] stamp_value;
		logic [BIN_W-1:0]  bin_hit;
		logic              counted;
		logic [TIME_W-1:0] bin_count;
	} histo_result_t;

	class latency_scoreboard;
		logic [TIME_W-1:0] interval;
		logic [CPN_W-1:0]  cpn;
		logic [TIME_W-1:0] accum [RINGS];
		logic [TIME_W-1:0] last_stamp_time [RINGS];
		logic [TIME_W-1:0] hist [RINGS][BINS];
		histo_result_t     expected_q[$];
		int                errors;

		function new();
			interval = '0;
			cpn = CPN_W'(1);
			errors = 0;
			foreach (accum[i]) begin
				accum[i] = '0;
				last_stamp_time[i] = '0;
			end
			foreach (hist[i, j])
				hist[i][j] = '0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
			if (idx == CFG_INTERVAL)
				interval = data;
			else if (idx == CFG_CPN)
				cpn = data[CPN_W-1:0];
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_item(logic [ACT_W-1:0] act, logic [RING_W-1:0] r,
			logic [TIME_W-1:0] t, logic [TIME_W-1:0] st, logic [BIN_W-1:0] b);
			histo_result_t res;
			logic [TIME_W-1:0] sum;
			logic [TIME_W-1:0] divisor;
			logic [TIME_W-1:0] lat;
			logic [BIN_W-1:0] slot;
			res = '0;
			case (act)
				ACT_STAMP: begin
					sum = accum[r] + (t - last_stamp_time[r]);
					if (sum >= interval) begin
						res.stamp_set = 1'b1;
						res.stamp_value = t;
						sum = '0;
					end
					accum[r] = sum;
					last_stamp_time[r] = t;
				end
				ACT_MEASURE: begin
					if (st != '0) begin
						divisor = (cpn == '0) ? TIME_W'(1) : TIME_W'(cpn);
						lat = (t - st) / divisor;
						slot = (lat < TIME_W'(BINS - 1)) ? BIN_W'(lat) : BIN_W'(BINS - 1);
						hist[r][slot] = hist[r][slot] + TIME_W'(1);
						res.bin_hit = slot;
						res.counted = 1'b1;
					end
				end
				ACT_READ: begin
					res.bin_count = hist[r][b];
				end
				default: ;
			endcase
			expected_q.push_back(res);
		endfunction

		task report_mismatch(string what, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
			$display("%0t: bad %s: got %h, expected %h", $time, what, got, want);
			errors++;
		endtask

		task check_result(histo_result_t got);
			histo_result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("result beat with nothing outstanding", '0, '0);
				return;
			end
			want = expected_q.pop_front();
			if (got.stamp_set !== want.stamp_set)
				report_mismatch("stamp_set", TIME_W'(got.stamp_set),
					TIME_W'(want.stamp_set));
			if (got.stamp_value !== want.stamp_value)
				report_mismatch("stamp_value", got.stamp_value, want.stamp_value);
			if (got.bin_hit !== want.bin_hit)
				report_mismatch("bin_hit", TIME_W'(got.bin_hit), TIME_W'(want.bin_hit));
			if (got.counted !== want.counted)
				report_mismatch("counted", TIME_W'(got.counted), TIME_W'(want.counted));
			if (got.bin_count !== want.bin_count)
				report_mismatch("bin_count", got.bin_count, want.bin_count);
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TIME_W-1:0]    cfg_data = '0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	logic [ACT_W-1:0]     action = '0;
	logic [RING_W-1:0]    ring = '0;
	logic [TIME_W-1:0]    now = '0;
	logic [TIME_W-1:0]    packet_stamp = '0;
	logic [BIN_W-1:0]     bin = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic                 stamp_set;
	logic [TIME_W-1:0]    stamp_value;
	logic [BIN_W-1:0]     bin_hit;
	logic                 counted;
	logic [TIME_W-1:0]    bin_count;

	latency_scoreboard sb = new();

	int send_idle = 0;
	int recv_idle = 0;
	int hold_asked = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int gen_cpn = 1;
	int step_max = 100;
	logic [TIME_W-1:0] ring_clock [RINGS];

	sampled_latency_histogram uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("sampled_latency_histogram: mismatch");
		$finish;
	end

	// receiver: random stall, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_asked != hold_seen) begin
			hold_seen <= hold_asked;
			hold_left <= 300;
			result_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_idle);
		end
	end

	always @(posedge clk) begin : watch
		histo_result_t seen;
		if (arst_n && item_valid && !item_stall)
			sb.note_item(action, ring, now, packet_stamp, bin);
		if (arst_n && result_valid && !result_stall) begin
			seen.stamp_set = stamp_set;
			seen.stamp_value = stamp_value;
			seen.bin_hit = bin_hit;
			seen.counted = counted;
			seen.bin_count = bin_count;
			sb.check_result(seen);
		end
	end

	task send_item(input logic [ACT_W-1:0] act, input logic [RING_W-1:0] r,
		input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] st,
		input logic [BIN_W-1:0] b);
		while ($urandom_range(0, 99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		ring <= r;
		now <= t;
		packet_stamp <= st;
		bin <= b;
		do @(posedge clk); while (item_stall !== 1'b0);
	endtask

	task set_config(input logic [TIME_W-1:0] interval, input logic [CPN_W-1:0] cpn);
		cfg_we <= 1'b1;
		cfg_index <= CFG_INTERVAL;
		cfg_data <= interval;
		@(posedge clk);
		sb.write_register(CFG_INTERVAL, interval);
		cfg_index <= CFG_CPN;
		cfg_data <= TIME_W'(cpn);
		@(posedge clk);
		sb.write_register(CFG_CPN, TIME_W'(cpn));
		cfg_we <= 1'b0;
		gen_cpn = (cpn == '0) ? 1 : int'(cpn);
	endtask

	task drain();
		int spent;
		item_valid <= 1'b0;
		spent = 0;
		while (sb.pending() != 0 && spent < 50000) begin
			@(posedge clk);
			spent++;
		end
		repeat (16) @(posedge clk);
	endtask

	task send_random_item();
		int pick;
		int lat_pick;
		logic [RING_W-1:0] r;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] st;
		logic [TIME_W-1:0] lat;
		logic [BIN_W-1:0] b;
		r = RING_W'($urandom_range(0, RINGS - 1));
		b = BIN_W'($urandom_range(0, BINS - 1));
		pick = $urandom_range(0, 99);
		st = {$urandom, $urandom};
		t = ring_clock[r] + TIME_W'($urandom_range(0, step_max));
		if ($urandom_range(0, 19) == 0)
			t = {$urandom, $urandom};
		if (pick < 40) begin
			ring_clock[r] = t;
			send_item(ACT_STAMP, r, t, st, b);
		end else if (pick < 80) begin
			lat_pick = $urandom_range(0, 99);
			if (lat_pick < 70)
				lat = TIME_W'($urandom_range(0, BINS - 2));
			else if (lat_pick < 85)
				lat = TIME_W'($urandom_range(BINS - 1, BINS + 8));
			else
				lat = TIME_W'($urandom);
			lat_pick = $urandom_range(0, 99);
			if (lat_pick < 8)
				st = '0;
			else if (lat_pick >= 5 + 8)
				st = t - (lat * TIME_W'(gen_cpn) + TIME_W'($urandom_range(0, gen_cpn - 1)));
			ring_clock[r] = t;
			send_item(ACT_MEASURE, r, t, st, b);
		end else if (pick < 95) begin
			send_item(ACT_READ, r, t, st, b);
		end else begin
			send_item(ACT_UNUSED, r, t, st, b);
		end
	endtask

	task run_phase(input logic [TIME_W-1:0] interval, input logic [CPN_W-1:0] cpn,
		input int step, input int count);
		drain();
		set_config(interval, cpn);
		step_max = step;
		repeat (count) send_random_item();
	endtask

	initial begin : stimulus
		foreach (ring_clock[i])
			ring_clock[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 28;
		recv_idle <= 59;
		set_config(64'd50, 8'd1);

		send_item(ACT_STAMP, 4'd0, 64'd10, 64'd0, 6'd0);
		send_item(ACT_STAMP, 4'd0, 64'd60, '1, '1);
		send_item(ACT_STAMP, 4'd15, '1, 64'd0, 6'd0);
		send_item(ACT_STAMP, 4'd15, 64'd5, 64'd0, 6'd0);
		send_item(ACT_MEASURE, 4'd1, 64'd100, 64'd0, 6'd0);
		send_item(ACT_MEASURE, 4'd1, 64'd100, 64'd100, 6'd0);
		send_item(ACT_MEASURE, 4'd1, 64'd162, 64'd100, 6'd0);
		send_item(ACT_MEASURE, 4'd1, 64'd163, 64'd100, 6'd0);
		send_item(ACT_MEASURE, 4'd1, 64'd1000, 64'd1, 6'd0);
		send_item(ACT_MEASURE, 4'd1, 64'd5, 64'd10, 6'd0);
		send_item(ACT_MEASURE, 4'd1, '1, 64'd1, 6'd0);
		send_item(ACT_MEASURE, 4'd1, 64'd0, '1, 6'd0);
		send_item(ACT_MEASURE, 4'd15, '1, '1, '1);
		send_item(ACT_READ, 4'd1, 64'd0, 64'd0, 6'd0);
		send_item(ACT_READ, 4'd1, 64'd0, 64'd0, 6'd62);
		send_item(ACT_READ, 4'd1, '1, '1, 6'd63);
		send_item(ACT_READ, 4'd1, 64'd0, 64'd0, 6'd1);
		send_item(ACT_READ, 4'd1, 64'd0, 64'd0, 6'd5);
		send_item(ACT_READ, 4'd15, 64'd0, 64'd0, 6'd0);
		send_item(ACT_READ, 4'd0, 64'd0, 64'd0, 6'd63);
		send_item(ACT_UNUSED, 4'd15, '1, '1, '1);
		send_item(ACT_UNUSED, 4'd0, 64'd0, 64'd0, 6'd0);
		send_item(ACT_STAMP, 4'd0, 64'd61, 64'd0, 6'd0);

		run_phase(64'd1000, 8'd3, 600, 306);

		send_idle = 59;
		recv_idle <= 28;
		run_phase(64'd0, 8'd255, 3000, 306);
		run_phase('1, 8'd0, 3000, 306);

		send_idle = 0;
		recv_idle <= 0;
		drain();
		set_config(TIME_W'($urandom_range(1, 5000)), 8'd1);
		step_max = 2000;
		// long result hold-off while items keep coming
		hold_asked <= hold_asked + 1;
		repeat (306) send_random_item();
		run_phase(64'd1, 8'd7, 400, 306);

		drain();
		if (sb.pending() != 0)
			sb.report_mismatch("expectations left over", TIME_W'(sb.pending()), '0);
		if (sb.errors == 0)
			$display("sampled_latency_histogram: match");
		else
			$display("sampled_latency_histogram: mismatch");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/slh_pkg.sv
hw/rtl/sampled_latency_histogram.sv
tb/sv/sampled_latency_histogram_test.sv
